// ===== sv/assert_macros.svh =====
// Assertion macros used by the sorted timer queue controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/stq_pkg.sv =====
// Package: types, codes and defaults of the sorted timer queue.
`default_nettype none
package stq_pkg;
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int HANDLES       = 16;
  localparam int MAX_FIRE      = 16;
  localparam int CNT_W         = 5;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_ADJUST = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNARMED = 2'd1;
  localparam logic [1:0] ST_ARMED   = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_ADD, ACT_INS, ACT_DEL, ACT_UNL, ACT_POP
  } act_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  handle;
    logic [31:0] expire_time;
    logic [15:0] user_token;
    logic [31:0] now_time;
  } item_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_handle;
    logic [15:0] fired_token;
    logic [1:0]  status;
    logic [4:0]  armed_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic load;
    act_e act;
  } ctl_t;

  typedef struct packed {
    logic             bad_handle;
    logic             armed;
    logic [3:0]       head_handle;
    logic [15:0]      head_token;
    logic             head_due;
    logic             next_due;
    logic [CNT_W-1:0] count;
  } stat_t;
endpackage
`default_nettype wire

// ===== sv/sorted_timer_queue_unit.sv =====
// Sorted timer queue: sorted cells with a sequencing controller.
// Add, delete and rejected operations: operands loaded, EXEC state acts, result
// registered. Adjust: unlink in EXEC, reinsert in ADJ, result registered. Tick: one
// result beat per cycle, one timer popped from the head cell per cycle, up to 16
// beats. Results cannot be stalled. Asynchronous active-low reset disarms all.
`default_nettype none
module sorted_timer_queue_unit import stq_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire item_t item_i,
  output logic       busy_o,
  output logic       result_valid_o,
  output result_t    result_o
);
  ctl_t  ctl;
  stat_t stat;

  stq_controller u_ctl (
    .clk_i, .rst_ni, .start_i, .op_i(item_i.operation), .stat_i(stat),
    .busy_o, .ctl_o(ctl), .result_valid_o, .result_o
  );

  stq_datapath #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk_i, .rst_ni, .item_i, .ctl_i(ctl), .stat_o(stat)
  );
endmodule
`default_nettype wire

// ===== sv/stq_datapath.sv =====
// Datapath: sorted timer cells, per-handle tokens and armed flags.
`default_nettype none
module stq_datapath import stq_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire ctl_t  ctl_i,
  output stat_t      stat_o
);
  logic [3:0]           hnd_q [SLOTS];
  logic [3:0]           hnd_d [SLOTS];
  logic [TIME_BITS-1:0] exp_q [SLOTS];
  logic [TIME_BITS-1:0] exp_d [SLOTS];
  logic [15:0]          tok_q [HANDLES];
  logic [HANDLES-1:0]   armed_q, armed_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [3:0]           h_q;
  logic [TIME_BITS-1:0] e_q, now_q;
  logic [15:0]          t_q;
  logic [SLOTS-1:0]     le, hit, after;
  logic                 ins, rem;

  assign ins = (ctl_i.act == ACT_ADD) || (ctl_i.act == ACT_INS);
  assign rem = (ctl_i.act == ACT_DEL) || (ctl_i.act == ACT_UNL);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      le[i]  = (32'(i) < 32'(cnt_q)) && (exp_q[i] <= e_q);
      hit[i] = (32'(i) < 32'(cnt_q)) && (hnd_q[i] == h_q);
    end
    after[0] = hit[0];
    for (int i = 1; i < SLOTS; i++) begin
      after[i] = hit[i] | after[i-1];
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    always_comb begin
      hnd_d[g] = hnd_q[g];
      exp_d[g] = exp_q[g];
      if (ins && !le[g]) begin
        if (g == 0) begin
          hnd_d[g] = h_q;
          exp_d[g] = e_q;
        end else if (le[(g>0)?g-1:0]) begin
          hnd_d[g] = h_q;
          exp_d[g] = e_q;
        end else begin
          hnd_d[g] = hnd_q[(g>0)?g-1:0];
          exp_d[g] = exp_q[(g>0)?g-1:0];
        end
      end else if (g < SLOTS-1 && ((rem && after[g]) || ctl_i.act == ACT_POP)) begin
        hnd_d[g] = hnd_q[(g<SLOTS-1)?g+1:g];
        exp_d[g] = exp_q[(g<SLOTS-1)?g+1:g];
      end
    end
  end

  always_comb begin
    armed_d = armed_q;
    cnt_d   = cnt_q;
    case (ctl_i.act)
      ACT_ADD: begin
        armed_d[h_q] = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
      end
      ACT_INS: cnt_d = cnt_q + CNT_W'(1);
      ACT_DEL: begin
        armed_d[h_q] = 1'b0;
        cnt_d = cnt_q - CNT_W'(1);
      end
      ACT_UNL: cnt_d = cnt_q - CNT_W'(1);
      ACT_POP: begin
        armed_d[hnd_q[0]] = 1'b0;
        cnt_d = cnt_q - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      cnt_q   <= '0;
    end else begin
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hnd_q <= hnd_d;
    exp_q <= exp_d;
    if (ctl_i.act == ACT_ADD) begin
      tok_q[h_q] <= t_q;
    end
    if (ctl_i.load) begin
      h_q   <= item_i.handle;
      e_q   <= TIME_BITS'(item_i.expire_time);
      t_q   <= item_i.user_token;
      now_q <= TIME_BITS'(item_i.now_time);
    end
  end

  assign stat_o.bad_handle  = 32'(h_q) >= SLOTS;
  assign stat_o.armed       = armed_q[h_q];
  assign stat_o.head_handle = hnd_q[0];
  assign stat_o.head_token  = tok_q[hnd_q[0]];
  assign stat_o.head_due    = (cnt_q != '0) && (exp_q[0] <= now_q);
  assign stat_o.next_due    = (cnt_q >= CNT_W'(2)) && (exp_q[1] <= now_q);
  assign stat_o.count       = cnt_q;
endmodule
`default_nettype wire

// ===== sv/stq_controller.sv =====
// Controller: operation sequencing and result beat generation.
`default_nettype none
`include "assert_macros.svh"
module stq_controller import stq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic [1:0] op_i,
  input  wire stat_t   stat_i,
  output logic         busy_o,
  output ctl_t         ctl_o,
  output logic         result_valid_o,
  output result_t      result_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ADJ  = 2'd2;
  localparam logic [1:0] S_TICK = 2'd3;

  logic [1:0] state_q, state_d, op_q, op_d;
  logic [3:0] n_q, n_d;
  logic       vld_d, vld_q;
  result_t    res_d, res_q;

  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    n_d       = n_q;
    ctl_o     = '{load: 1'b0, act: ACT_NONE};
    vld_d     = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    res_d.armed_count = stat_i.count;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          op_d    = op_i;
          n_d     = '0;
          state_d = (op_i == OP_TICK) ? S_TICK : S_EXEC;
        end
      end
      S_EXEC: begin
        vld_d   = 1'b1;
        state_d = S_IDLE;
        if (stat_i.bad_handle) begin
          res_d.status = ST_UNARMED;
        end else if (op_q == OP_ADD) begin
          if (stat_i.armed) begin
            res_d.status = ST_ARMED;
          end else begin
            ctl_o.act = ACT_ADD;
            res_d.armed_count = stat_i.count + 5'd1;
          end
        end else if (!stat_i.armed) begin
          res_d.status = ST_UNARMED;
        end else if (op_q == OP_ADJUST) begin
          ctl_o.act = ACT_UNL;
          vld_d     = 1'b0;
          state_d   = S_ADJ;
        end else begin
          ctl_o.act = ACT_DEL;
          res_d.armed_count = stat_i.count - 5'd1;
        end
      end
      S_ADJ: begin
        ctl_o.act = ACT_INS;
        vld_d     = 1'b1;
        res_d.armed_count = stat_i.count + 5'd1;
        state_d   = S_IDLE;
      end
      S_TICK: begin
        vld_d = 1'b1;
        if (stat_i.head_due) begin
          ctl_o.act          = ACT_POP;
          res_d.fired        = 1'b1;
          res_d.fired_handle = stat_i.head_handle;
          res_d.fired_token  = stat_i.head_token;
          res_d.armed_count  = stat_i.count - 5'd1;
          res_d.last         = (n_q == 4'(MAX_FIRE - 1)) || !stat_i.next_due;
          n_d                = n_q + 4'd1;
          if (res_d.last) begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
      n_q     <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      n_q     <= n_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = vld_q;
  assign result_o       = res_q;

  `ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o)
  `ASSERT_IMP(a_pop_due, ctl_o.act == ACT_POP, stat_i.head_due)
  `ASSERT_IMP(a_idle_no_act, state_q == S_IDLE, ctl_o.act == ACT_NONE)
endmodule
`default_nettype wire
